### hdl/u2u8_pkg.sv
// Shared types, constants and byte-forming functions for the UTF-16 to UTF-8 transcoder.
// Used by the front, queue and back modules and by the top level; depends on nothing else.
`timescale 1ns / 1ps

package u2u8_pkg;

  localparam int unsigned CodeUnitW    = 16;
  localparam int unsigned ScalarW      = 21;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned CountW       = 3;
  localparam int unsigned FifoDepthDef = 2;

  // Input mode codes carried in tuser.
  localparam logic MODE_UNIT = 1'b0;
  localparam logic MODE_EOL  = 1'b1;

  // Result status codes carried in tuser.
  localparam logic STATUS_DATA = 1'b0;
  localparam logic STATUS_ERR  = 1'b1;

  localparam logic [5:0] SURR_TAG_HIGH = 6'b110110;
  localparam logic [5:0] SURR_TAG_LOW  = 6'b110111;

  localparam logic [ScalarW-1:0] NEWLINE_SCALAR = ScalarW'(8'h0A);
  localparam logic [ScalarW-1:0] SUPP_BASE      = ScalarW'(32'h10000);
  localparam logic [CountW-1:0]  BOM_LEN        = 3'd3;

  // One queued job: optional byte order mark, then an error or a scalar.
  typedef struct packed {
    logic               bom;
    logic               err;
    logic [CountW-1:0]  nbytes;
    logic [ScalarW-1:0] scalar;
  } job_t;

  function automatic logic [ByteW-1:0] bom_byte(input logic [1:0] idx);
    logic [ByteW-1:0] b;
    case (idx)
      2'd0:    b = 8'hEF;
      2'd1:    b = 8'hBB;
      default: b = 8'hBF;
    endcase
    return b;
  endfunction

  // Byte number idx of the UTF-8 form of s, which is nbytes long.
  function automatic logic [ByteW-1:0] utf8_byte(input logic [ScalarW-1:0] s,
                                                 input logic [CountW-1:0]  nbytes,
                                                 input logic [1:0]         idx);
    logic [ByteW-1:0] b;
    case (nbytes)
      3'd1: b = {1'b0, s[6:0]};
      3'd2: b = (idx == 2'd0) ? {3'b110, s[10:6]} : {2'b10, s[5:0]};
      3'd3: begin
        case (idx)
          2'd0:    b = {4'b1110, s[15:12]};
          2'd1:    b = {2'b10, s[11:6]};
          default: b = {2'b10, s[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = {5'b11110, s[20:18]};
          2'd1:    b = {2'b10, s[17:12]};
          2'd2:    b = {2'b10, s[11:6]};
          default: b = {2'b10, s[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

### hdl/u2u8_front.sv
// Front end: classifies each accepted code unit or end-of-line mark and builds a job.
// Holds the surrogate, mark and error state; depends on u2u8_pkg.
`timescale 1ns / 1ps

module u2u8_front
  import u2u8_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 accept,
  input  logic                 mode,
  input  logic [CodeUnitW-1:0] code_unit,
  output logic                 push,
  output job_t                 job
);

  logic       bom_enable_r, bom_enable_nxt;
  logic       bom_done_r, bom_done_nxt;
  logic       pending_r, pending_nxt;
  logic       failed_r, failed_nxt;
  logic [9:0] held_r, held_nxt;

  logic is_high, is_low;

  assign is_high = (code_unit[15:10] == SURR_TAG_HIGH);
  assign is_low  = (code_unit[15:10] == SURR_TAG_LOW);

  always_comb begin
    bom_enable_nxt = cfg_wr_en ? cfg_wr_data : bom_enable_r;
    bom_done_nxt   = bom_done_r;
    pending_nxt    = pending_r;
    failed_nxt     = failed_r;
    held_nxt       = held_r;
    job.bom        = 1'b0;
    job.err        = 1'b0;
    job.nbytes     = '0;
    job.scalar     = ScalarW'(code_unit);

    if (accept && !failed_r) begin
      bom_done_nxt = 1'b1;
      job.bom      = !bom_done_r && bom_enable_r;
      if (mode == MODE_EOL) begin
        if (pending_r) begin
          job.err = 1'b1;
        end else begin
          job.scalar = NEWLINE_SCALAR;
          job.nbytes = 3'd1;
        end
      end else if (pending_r) begin
        if (is_low) begin
          job.scalar = SUPP_BASE + ScalarW'({held_r, code_unit[9:0]});
          job.nbytes = 3'd4;
        end else begin
          job.err = 1'b1;
        end
      end else if (is_high) begin
        pending_nxt = 1'b1;
        held_nxt    = code_unit[9:0];
      end else if (is_low) begin
        job.err = 1'b1;
      end else if (code_unit[15:7] == '0) begin
        job.nbytes = 3'd1;
      end else if (code_unit[15:11] == '0) begin
        job.nbytes = 3'd2;
      end else begin
        job.nbytes = 3'd3;
      end

      if (job.err) begin
        job.nbytes  = 3'd1;
        failed_nxt  = 1'b1;
        pending_nxt = 1'b0;
        held_nxt    = '0;
      end else if (job.nbytes != '0) begin
        pending_nxt = 1'b0;
        held_nxt    = '0;
      end
    end
  end

  assign push = accept && !failed_r && (job.bom || (job.nbytes != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bom_enable_r <= 1'b1;
      bom_done_r   <= 1'b0;
      pending_r    <= 1'b0;
      failed_r     <= 1'b0;
      held_r       <= '0;
    end else begin
      bom_enable_r <= bom_enable_nxt;
      bom_done_r   <= bom_done_nxt;
      pending_r    <= pending_nxt;
      failed_r     <= failed_nxt;
      held_r       <= held_nxt;
    end
  end

endmodule

### hdl/u2u8_fifo.sv
// Short job queue between the front end and the byte emitter.
// Register based, DEPTH entries (two or more); depends on u2u8_pkg for job_t.
`timescale 1ns / 1ps

module u2u8_fifo
  import u2u8_pkg::*;
#(
  parameter int unsigned DEPTH = FifoDepthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output logic rd_valid,
  output job_t rd_job
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  job_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == FullCnt);
  assign rd_valid = (count_r != '0);
  assign rd_job   = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### hdl/u2u8_back.sv
// Back end: takes jobs from the queue and sends their bytes one per cycle
// when not stalled, on the registered result channel; depends on u2u8_pkg.
`timescale 1ns / 1ps

module u2u8_back
  import u2u8_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  job_t             job_in,
  output logic             job_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ByteW-1:0] out_byte,
  output logic             out_status,
  output logic             out_last
);

  job_t              job_r, job_nxt;
  logic              busy_r, busy_nxt;
  logic [CountW-1:0] idx_r, idx_nxt;
  logic              valid_r, valid_nxt;
  logic [ByteW-1:0]  byte_r, byte_nxt;
  logic              status_r, status_nxt;
  logic              last_r, last_nxt;

  logic              out_free, is_last, in_bom;
  logic [CountW-1:0] bom_ofs, total, sidx;

  assign out_free = !valid_r || out_ready;
  assign bom_ofs  = job_r.bom ? BOM_LEN : '0;
  assign total    = bom_ofs + job_r.nbytes;
  assign is_last  = (idx_r == total - 1'b1);
  assign in_bom   = job_r.bom && (idx_r < BOM_LEN);
  assign sidx     = idx_r - bom_ofs;
  assign job_pop  = job_valid && (!busy_r || (out_free && is_last));

  always_comb begin
    job_nxt    = job_r;
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    valid_nxt  = valid_r;
    byte_nxt   = byte_r;
    status_nxt = status_r;
    last_nxt   = last_r;

    if (out_free) begin
      valid_nxt = busy_r;
      if (busy_r) begin
        last_nxt = is_last;
        if (in_bom) begin
          byte_nxt   = bom_byte(idx_r[1:0]);
          status_nxt = STATUS_DATA;
        end else if (job_r.err) begin
          byte_nxt   = '0;
          status_nxt = STATUS_ERR;
        end else begin
          byte_nxt   = utf8_byte(job_r.scalar, job_r.nbytes, sidx[1:0]);
          status_nxt = STATUS_DATA;
        end
        idx_nxt = is_last ? '0 : idx_r + 1'b1;
        if (is_last) begin
          busy_nxt = job_valid;
        end
      end
    end

    if (job_pop) begin
      job_nxt  = job_in;
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    byte_r   <= byte_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_byte   = byte_r;
  assign out_status = status_r;
  assign out_last   = last_r;

endmodule

### hdl/utf16_to_utf8_transcoder.sv
// Top level of the UTF-16 to UTF-8 transcoder: front end, job queue and byte emitter.
// Depends on u2u8_pkg, u2u8_front, u2u8_fifo and u2u8_back.
//
// The input stream carries one UTF-16 code unit per transfer in in_tdata, or an
// end-of-line mark when in_tuser is high. The output stream carries one UTF-8 byte per
// transfer; out_tuser flags an error result and out_tlast marks the final byte caused
// by one input transfer. A unit that produces nothing (a held high surrogate, or
// anything after an error) yields no output transfer at all.
// Each item goes through a queue entry and the job register to the output register.
// Throughput: while out_tready is high, the emitter sends one byte per cycle and short
// items stream at one per cycle, as the input side accepts while the queue has room.
// An item has one to four bytes, three more for the byte order mark.
// An encoding error sends one byte-zero result with out_tuser set and then the block
// swallows every input transfer until reset.
// Reset (rst_n low at a clock edge) empties the queue and output register, clears the
// surrogate and error state and sets the byte order mark enable. If the receiver holds
// out_tready low, the output register holds its byte, the emitter stalls, and once the
// queue fills in_tready drops; nothing is lost.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder
  import u2u8_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration: bit 0 is the byte order mark enable.
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  // Input stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [CodeUnitW-1:0] in_tdata,   // [15:0] code_unit
  input  logic                 in_tuser,   // [0] mode
  // Output stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [ByteW-1:0]     out_tdata,  // [7:0] out_byte
  output logic                 out_tuser,  // [0] status
  output logic                 out_tlast
);

  logic accept;
  logic push, full;
  job_t push_job;
  logic q_valid, q_pop;
  job_t q_job;

  // The queue's full flag is the only thing that holds back the input side.
  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  u2u8_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .accept     (accept),
    .mode       (in_tuser),
    .code_unit  (in_tdata),
    .push       (push),
    .job        (push_job)
  );

  u2u8_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_job  (push_job),
    .full    (full),
    .pop     (q_pop),
    .rd_valid(q_valid),
    .rd_job  (q_job)
  );

  u2u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_in    (q_job),
    .job_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_status(out_tuser),
    .out_last  (out_tlast)
  );

endmodule

### tb/utf8_stream_checker.sv
// Stream checker for the UTF-16 to UTF-8 transcoder: predicts the output bytes from
// the input and configuration transfers and compares them with the output stream.
// Depends on u2u8_pkg for widths and codes.
`timescale 1ns / 1ps

module utf8_stream_checker
  import u2u8_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [CodeUnitW-1:0] in_tdata,
  input  logic                 in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [ByteW-1:0]     out_tdata,
  input  logic                 out_tuser,
  input  logic                 out_tlast,
  output int unsigned          mismatches,
  output int unsigned          outstanding
);

  localparam logic [23:0] BOM_SEQ = 24'hEFBBBF;

  typedef struct {
    logic [ByteW-1:0] octet;
    logic             status;
    logic             tail;
  } utf8_result_t;

  utf8_result_t expected_bytes[$];
  utf8_result_t item_bytes[$];
  utf8_result_t head;

  logic        bom_en;
  logic [9:0]  held_bits;
  logic        high_held;
  logic        bom_sent;
  logic        stopped;
  int unsigned errors_seen;

  task automatic queue_byte(input logic [ByteW-1:0] b, input logic st);
    utf8_result_t r;
    r.octet    = b;
    r.status   = st;
    r.tail     = 1'b0;
    item_bytes = {item_bytes, r};
  endtask

  task automatic queue_scalar(input logic [ScalarW-1:0] s);
    if (s < 21'h80) begin
      queue_byte(8'(s), STATUS_DATA);
    end else if (s < 21'h800) begin
      queue_byte(8'hC0 | 8'(s >> 6), STATUS_DATA);
      queue_byte(8'h80 | 8'(s & 21'h3F), STATUS_DATA);
    end else if (s < 21'h10000) begin
      queue_byte(8'hE0 | 8'(s >> 12), STATUS_DATA);
      queue_byte(8'h80 | 8'((s >> 6) & 21'h3F), STATUS_DATA);
      queue_byte(8'h80 | 8'(s & 21'h3F), STATUS_DATA);
    end else begin
      queue_byte(8'hF0 | 8'((s >> 18) & 21'h07), STATUS_DATA);
      queue_byte(8'h80 | 8'((s >> 12) & 21'h3F), STATUS_DATA);
      queue_byte(8'h80 | 8'((s >> 6) & 21'h3F), STATUS_DATA);
      queue_byte(8'h80 | 8'(s & 21'h3F), STATUS_DATA);
    end
  endtask

  // An encoding error stops the stream for good.
  task automatic stop_stream();
    stopped   = 1'b1;
    high_held = 1'b0;
    held_bits = '0;
    queue_byte(8'h00, STATUS_ERR);
  endtask

  task automatic predict_utf8(input logic mode, input logic [CodeUnitW-1:0] cu);
    logic is_high;
    logic is_low;
    int   i;
    is_high = (cu[15:10] == SURR_TAG_HIGH);
    is_low  = (cu[15:10] == SURR_TAG_LOW);
    item_bytes.delete();
    if (stopped) return;
    if (!bom_sent) begin
      bom_sent = 1'b1;
      if (bom_en) begin
        for (i = 0; i < 3; i++) queue_byte(BOM_SEQ[23 - 8 * i -: 8], STATUS_DATA);
      end
    end
    if (mode == MODE_EOL) begin
      if (high_held) stop_stream();
      else queue_byte(NEWLINE_SCALAR[7:0], STATUS_DATA);
    end else if (high_held) begin
      if (is_low) begin
        high_held = 1'b0;
        queue_scalar(SUPP_BASE + ScalarW'({held_bits, cu[9:0]}));
        held_bits = '0;
      end else begin
        stop_stream();
      end
    end else if (is_high) begin
      held_bits = cu[9:0];
      high_held = 1'b1;
    end else if (is_low) begin
      stop_stream();
    end else begin
      queue_scalar(ScalarW'(cu));
    end
    if (item_bytes.size() != 0) item_bytes[item_bytes.size() - 1].tail = 1'b1;
    foreach (item_bytes[j]) expected_bytes = {expected_bytes, item_bytes[j]};
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bom_en      = 1'b1;
      held_bits   = '0;
      high_held   = 1'b0;
      bom_sent    = 1'b0;
      stopped     = 1'b0;
      errors_seen = 0;
      expected_bytes.delete();
    end else begin
      if (cfg_wr_en) bom_en = cfg_wr_data;
      if (in_tvalid && in_tready) predict_utf8(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          errors_seen++;
          $display("%0t: unexpected transfer, expected none, got byte %02h status %0b last %0b",
                   $time, out_tdata, out_tuser, out_tlast);
        end else begin
          head = expected_bytes.pop_front();
          if (out_tdata !== head.octet) begin
            errors_seen++;
            $display("%0t: out_tdata expected %02h, got %02h", $time, head.octet, out_tdata);
          end
          if (out_tuser !== head.status) begin
            errors_seen++;
            $display("%0t: out_tuser expected %0b, got %0b", $time, head.status, out_tuser);
          end
          if (out_tlast !== head.tail) begin
            errors_seen++;
            $display("%0t: out_tlast expected %0b, got %0b", $time, head.tail, out_tlast);
          end
        end
      end
    end
    mismatches  <= errors_seen;
    outstanding <= expected_bytes.size();
  end

endmodule

### tb/tb.sv
// Top of the transcoder testbench: clock, reset, stimulus and the final verdict.
// Depends on u2u8_pkg, utf16_to_utf8_transcoder and utf8_stream_checker.
`timescale 1ns / 1ps

module tb
  import u2u8_pkg::*;
();

  // Generous bound on the whole run; the slowest legal run is far below this.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 220;
  localparam int unsigned SQUEEZE_LEN  = 300;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic                 cfg_wr_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [CodeUnitW-1:0] in_tdata;   // [15:0] code_unit
  logic                 in_tuser;   // [0] mode
  logic                 out_tvalid;
  logic                 out_tready;
  logic [ByteW-1:0]     out_tdata;  // [7:0] out_byte
  logic                 out_tuser;  // [0] status
  logic                 out_tlast;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycles = 0;

  // Bumped by the stimulus to ask the receiver for one long hold-off.
  int unsigned squeeze_reqs = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  utf16_to_utf8_transcoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  utf8_stream_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // A hung block must still end the run with a verdict.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Length of one random idle stretch, now and then a much longer one.
  function automatic int unsigned idle_span();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Offers one item, after an optional random gap, and returns at the edge where the
  // transfer takes place. The valid stays high so that the next item can follow
  // back to back; only one assignment to it is made per edge.
  task automatic send_unit(input logic mode, input logic [CodeUnitW-1:0] cu);
    if ($urandom_range(0, 1) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= CodeUnitW'($urandom);
      repeat (idle_span()) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cu;
    in_tuser  <= mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Ends the current burst and waits for every predicted byte to arrive. A held high
  // surrogate predicts nothing, so the wait goes on past the last expected byte.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register writes happen only with the block drained.
  task automatic write_bom(input logic value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [CodeUnitW-1:0] three_byte_unit();
    logic [CodeUnitW-1:0] u;
    // Picks from 0800..D7FF and E000..FFFF, skipping the surrogate range.
    u = CodeUnitW'($urandom_range(16'h0800, 16'hF7FF));
    if (u >= 16'hD800) u = u + 16'h0800;
    return u;
  endfunction

  function automatic logic [CodeUnitW-1:0] high_unit();
    return CodeUnitW'($urandom_range(16'hD800, 16'hDBFF));
  endfunction

  function automatic logic [CodeUnitW-1:0] low_unit();
    return CodeUnitW'($urandom_range(16'hDC00, 16'hDFFF));
  endfunction

  // The receiver runs on its own: ready bursts, short and long stalls, and one long
  // hold-off on request during which the sender keeps offering items until the
  // queue fills and in_tready drops.
  initial begin : receiver
    int unsigned squeeze_done;
    squeeze_done = 0;
    out_tready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (squeeze_done != squeeze_reqs) begin
        squeeze_done = squeeze_reqs;
        out_tready <= 1'b0;
        repeat (SQUEEZE_LEN) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (idle_span()) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned ending;
    int unsigned i;
    logic        first_bom;

    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= MODE_UNIT;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Only the setting at the first accepted item decides whether the byte order
    // mark is sent, so that one is random; later writes must leave the stream alone.
    first_bom = 1'($urandom_range(0, 1));
    write_bom(first_bom);

    // Directed part. The very first item is a high surrogate, so a byte order mark,
    // if enabled, is the only output of that item and carries the last flag.
    send_unit(MODE_UNIT, 16'hD800);
    send_unit(MODE_UNIT, 16'hDC00);
    // The boundaries of the one, two and three byte forms.
    send_unit(MODE_UNIT, 16'h0000);
    send_unit(MODE_UNIT, 16'h007F);
    send_unit(MODE_UNIT, 16'h0080);
    send_unit(MODE_UNIT, 16'h07FF);
    send_unit(MODE_UNIT, 16'h0800);
    send_unit(MODE_UNIT, 16'hD7FF);
    send_unit(MODE_UNIT, 16'hE000);
    send_unit(MODE_UNIT, 16'hFFFF);
    send_unit(MODE_UNIT, 16'h5555);
    // End-of-line marks ignore the code unit, even one that looks like a surrogate.
    send_unit(MODE_EOL, 16'hFFFF);
    send_unit(MODE_EOL, 16'hD800);
    send_unit(MODE_EOL, 16'h0000);
    // Surrogate pairs at the corners of the supplementary range.
    send_unit(MODE_UNIT, 16'hDBFF);
    send_unit(MODE_UNIT, 16'hDFFF);
    send_unit(MODE_UNIT, 16'hDBFF);
    send_unit(MODE_UNIT, 16'hDC00);
    send_unit(MODE_UNIT, 16'hD800);
    send_unit(MODE_UNIT, 16'hDFFF);
    send_unit(MODE_UNIT, 16'hAAAA);

    write_bom(~first_bom);

    // Random part: well-formed text only, since any encoding error stops the stream
    // until reset. The receiver is asked for its long hold-off right at the start.
    squeeze_reqs++;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          send_unit(MODE_UNIT, CodeUnitW'($urandom_range(0, 16'h007F)));
          sent += 1;
        end
        3, 4: begin
          send_unit(MODE_UNIT, CodeUnitW'($urandom_range(16'h0080, 16'h07FF)));
          sent += 1;
        end
        5, 6: begin
          send_unit(MODE_UNIT, three_byte_unit());
          sent += 1;
        end
        7, 8: begin
          send_unit(MODE_UNIT, high_unit());
          send_unit(MODE_UNIT, low_unit());
          sent += 2;
        end
        default: begin
          send_unit(MODE_EOL, CodeUnitW'($urandom));
          sent += 1;
        end
      endcase
    end

    write_bom(first_bom);

    // One broken sequence per run closes the stream, since only reset clears the
    // error; the alternative ending leaves a high surrogate held with nothing after.
    ending = $urandom_range(0, 4);
    case (ending)
      0: send_unit(MODE_UNIT, low_unit());
      1: begin
        send_unit(MODE_UNIT, high_unit());
        send_unit(MODE_UNIT, high_unit());
      end
      2: begin
        send_unit(MODE_UNIT, high_unit());
        if ($urandom_range(0, 1) == 0) send_unit(MODE_UNIT, three_byte_unit());
        else send_unit(MODE_UNIT, CodeUnitW'($urandom_range(0, 16'h007F)));
      end
      3: begin
        send_unit(MODE_UNIT, high_unit());
        send_unit(MODE_EOL, CodeUnitW'($urandom));
      end
      default: send_unit(MODE_UNIT, high_unit());
    endcase
    // After an error everything is swallowed, whatever it holds.
    if (ending != 4) begin
      for (i = 0; i < 12; i++) send_unit(1'($urandom_range(0, 1)), CodeUnitW'($urandom));
    end

    wait_idle();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
